>>> rtl/zoh_resampler_saturating_mixer_unit_macros.svh
// assertion helpers for the resampler mixer, empty when SYNTH is defined
`ifndef ZOH_RESAMPLER_SATURATING_MIXER_UNIT_MACROS_SVH
`define ZOH_RESAMPLER_SATURATING_MIXER_UNIT_MACROS_SVH
`ifndef SYNTH
// condition must hold at every edge outside reset
`define ZRSM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);
// antecedent implies consequent in the same cycle
`define ZRSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define ZRSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ZRSM_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ZRSM_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ZRSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/zrsm_pkg.sv
`default_nettype none
package zrsm_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 256;
  localparam int unsigned QUEUE_DEPTH = 2;
  // magnitude bits of a 16 x 8 bit product
  localparam int unsigned DIV_BITS = 23;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic RST_ENABLED = 1'b0;
  localparam logic RST_STEREO = 1'b1;
  localparam logic [25:0] RST_PHASE_STEP = 26'd4194304;
  localparam logic [31:0] RST_PHASE_MODULUS = 32'd6144000;
  localparam logic [7:0] RST_GAIN_NUM = 8'd1;
  localparam logic [7:0] RST_GAIN_DEN = 8'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLED       = 3'd0,
    CFG_STEREO        = 3'd1,
    CFG_PHASE_STEP    = 3'd2,
    CFG_PHASE_MODULUS = 3'd3,
    CFG_GAIN_NUM      = 3'd4,
    CFG_GAIN_DEN      = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic        enabled;
    logic        stereo;
    logic [25:0] phase_step;
    logic [31:0] phase_modulus;
    logic [7:0]  gain_num;
    logic [7:0]  gain_den;
  } cfg_t;

  typedef enum logic {
    CMD_PUSH   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
    logic               mixed;
    logic               underrun;
    logic               dropped;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_DECODE,
    ST_LOAD,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_SIGN,
    ST_SUM,
    ST_ADV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

>>> rtl/zrsm_front.sv
`default_nettype none
module zrsm_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic               mode,
  input  wire logic signed [15:0] frame_left,
  input  wire logic signed [15:0] frame_right,
  input  wire logic signed [15:0] host_left,
  input  wire logic signed [15:0] host_right,
  output logic                    cmd_valid,
  output zrsm_pkg::cmd_t          cmd,
  input  wire logic               cmd_take
);

  localparam int unsigned QD = zrsm_pkg::QUEUE_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  zrsm_pkg::cmd_t q [QD];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QCW-1:0] count;
  logic           push;
  logic           pop;
  zrsm_pkg::cmd_t incoming;

  assign item_ready = (count != QCW'(QD));
  assign cmd_valid = (count != '0);
  assign cmd = q[rptr];
  assign push = item_valid && item_ready;
  assign pop = cmd_take && cmd_valid;

  // classify: keep only the sample pair the item's mode calls for
  always_comb begin
    incoming.kind = mode ? zrsm_pkg::CMD_SAMPLE : zrsm_pkg::CMD_PUSH;
    incoming.left = mode ? host_left : frame_left;
    incoming.right = mode ? host_right : frame_right;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QAW'(QD - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QAW'(QD - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/zrsm_frame_fifo.sv
`default_nettype none
module zrsm_frame_fifo #(
  parameter int unsigned DEPTH = zrsm_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire zrsm_pkg::fifo_ctl_t        ctl,
  input  wire logic [31:0]                wdata,
  output logic [31:0]                     rdata,
  output zrsm_pkg::fifo_stat_t            stat,
  output logic [$clog2(DEPTH + 1)-1:0]    count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;

  assign stat.empty = (count == '0);
  assign stat.full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wptr] <= wdata;
    end
    if (ctl.pop) begin
      rdata <= mem[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (ctl.pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/zrsm_back.sv
`default_nettype none
module zrsm_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire zrsm_pkg::cfg_t       cfg,
  input  wire logic                 cmd_valid,
  input  wire zrsm_pkg::cmd_t       cmd,
  output logic                      cmd_take,
  output zrsm_pkg::fifo_ctl_t       fifo_ctl,
  output logic [31:0]               fifo_wdata,
  input  wire logic [31:0]          fifo_rdata,
  input  wire zrsm_pkg::fifo_stat_t fifo_stat,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output zrsm_pkg::res_t            res
);

  localparam int unsigned DB = zrsm_pkg::DIV_BITS;
  localparam int unsigned DCW = $clog2(DB);

  zrsm_pkg::state_t   state;
  zrsm_pkg::state_t   state_next;
  zrsm_pkg::cmd_t     cur;
  zrsm_pkg::res_t     pend;
  logic signed [15:0] held [2];
  logic               held_valid;
  logic               pop_d;
  logic [32:0]        phase;
  logic signed [24:0] prod [2];
  logic [DB-1:0]      dvd [2];
  logic [7:0]         rem [2];
  logic               neg [2];
  logic signed [23:0] gain [2];
  logic [DCW-1:0]     div_cnt;
  logic               out_load;

  logic [7:0]         den;
  logic               bypass;
  logic               phase_ge;
  logic [8:0]         rem_sh [2];
  logic               q_bit [2];
  logic [DB-1:0]      dvd_next [2];
  logic [7:0]         rem_next [2];
  logic signed [24:0] mag [2];
  logic signed [25:0] sum_l;
  logic signed [25:0] sum_r;
  logic signed [24:0] mono_sum;
  logic signed [24:0] mono_half;
  logic signed [25:0] sum_m;
  logic signed [15:0] sat_l;
  logic signed [15:0] sat_r;
  logic signed [15:0] sat_m;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] v);
    if (v > 26'sd32767) begin
      return 16'sh7fff;
    end else if (v < -26'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  assign den = (cfg.gain_den == 8'd0) ? 8'd1 : cfg.gain_den;
  assign bypass = !cfg.enabled || (cfg.phase_modulus == 32'd0);
  assign phase_ge = (phase >= {1'b0, cfg.phase_modulus});
  assign fifo_wdata = {cur.right, cur.left};

  // one restoring step per cycle, both channels share the divisor
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {rem[i], dvd[i][DB-1]};
      q_bit[i] = (rem_sh[i] >= {1'b0, den});
      rem_next[i] = q_bit[i] ? 8'(rem_sh[i] - {1'b0, den}) : rem_sh[i][7:0];
      dvd_next[i] = {dvd[i][DB-2:0], q_bit[i]};
      mag[i] = prod[i][24] ? -prod[i] : prod[i];
    end
  end

  // mixing and saturation
  always_comb begin
    sum_l = {{10{cur.left[15]}}, cur.left} + {{2{gain[0][23]}}, gain[0]};
    sum_r = {{10{cur.right[15]}}, cur.right} + {{2{gain[1][23]}}, gain[1]};
    mono_sum = {gain[0][23], gain[0]} + {gain[1][23], gain[1]};
    // halve toward zero
    mono_half = $signed(mono_sum + {24'd0, mono_sum[24]}) >>> 1;
    sum_m = {{10{cur.left[15]}}, cur.left} + {mono_half[24], mono_half};
    sat_l = sat16(sum_l);
    sat_r = sat16(sum_r);
    sat_m = sat16(sum_m);
  end

  always_comb begin
    state_next = state;
    case (state)
      zrsm_pkg::ST_FETCH: begin
        if (cmd_valid) begin
          state_next = zrsm_pkg::ST_DECODE;
        end
      end
      zrsm_pkg::ST_DECODE: begin
        if (cur.kind == zrsm_pkg::CMD_PUSH) begin
          state_next = fifo_stat.full ? zrsm_pkg::ST_OUT : zrsm_pkg::ST_FETCH;
        end else if (bypass) begin
          state_next = zrsm_pkg::ST_OUT;
        end else if (!held_valid) begin
          state_next = fifo_stat.empty ? zrsm_pkg::ST_OUT : zrsm_pkg::ST_LOAD;
        end else begin
          state_next = zrsm_pkg::ST_MUL;
        end
      end
      zrsm_pkg::ST_LOAD: state_next = zrsm_pkg::ST_MUL;
      zrsm_pkg::ST_MUL: state_next = zrsm_pkg::ST_ABS;
      zrsm_pkg::ST_ABS: state_next = zrsm_pkg::ST_DIV;
      zrsm_pkg::ST_DIV: begin
        if (div_cnt == DCW'(DB - 1)) begin
          state_next = zrsm_pkg::ST_SIGN;
        end
      end
      zrsm_pkg::ST_SIGN: state_next = zrsm_pkg::ST_SUM;
      zrsm_pkg::ST_SUM: state_next = zrsm_pkg::ST_ADV;
      zrsm_pkg::ST_ADV: begin
        if (!phase_ge || fifo_stat.empty) begin
          state_next = zrsm_pkg::ST_OUT;
        end
      end
      zrsm_pkg::ST_OUT: begin
        if (!result_valid || result_ready) begin
          state_next = zrsm_pkg::ST_FETCH;
        end
      end
      default: state_next = zrsm_pkg::ST_FETCH;
    endcase
  end

  always_comb begin
    cmd_take = 1'b0;
    fifo_ctl = '0;
    out_load = 1'b0;
    case (state)
      zrsm_pkg::ST_FETCH: cmd_take = cmd_valid;
      zrsm_pkg::ST_DECODE: begin
        if (cur.kind == zrsm_pkg::CMD_PUSH) begin
          fifo_ctl.push = !fifo_stat.full;
        end else begin
          fifo_ctl.pop = !bypass && !held_valid && !fifo_stat.empty;
        end
      end
      zrsm_pkg::ST_ADV: fifo_ctl.pop = phase_ge && !fifo_stat.empty;
      zrsm_pkg::ST_OUT: out_load = !result_valid || result_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zrsm_pkg::ST_FETCH;
      held_valid <= 1'b0;
      pop_d <= 1'b0;
      phase <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      pop_d <= fifo_ctl.pop;
      if (pop_d) begin
        held_valid <= 1'b1;
      end
      if (state == zrsm_pkg::ST_SUM) begin
        phase <= phase + {7'd0, cfg.phase_step};
      end else if (fifo_ctl.pop && state == zrsm_pkg::ST_ADV) begin
        phase <= phase - {1'b0, cfg.phase_modulus};
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // popped frame is taken into held from the registered read data when pop_d is set
    if (pop_d) begin
      held[0] <= fifo_rdata[15:0];
      held[1] <= fifo_rdata[31:16];
    end
    if (cmd_take) begin
      cur <= cmd;
    end
    if (out_load) begin
      res <= pend;
    end
    case (state)
      zrsm_pkg::ST_DECODE: begin
        if (cur.kind == zrsm_pkg::CMD_PUSH) begin
          pend.out_left <= '0;
          pend.out_right <= '0;
          pend.mixed <= 1'b0;
          pend.underrun <= 1'b0;
          pend.dropped <= 1'b1;
        end else begin
          pend.out_left <= cur.left;
          pend.out_right <= cur.right;
          pend.mixed <= 1'b0;
          pend.underrun <= 1'b0;
          pend.dropped <= 1'b0;
        end
      end
      zrsm_pkg::ST_MUL: begin
        for (int i = 0; i < 2; i++) begin
          prod[i] <= 25'(held[i]) * $signed({17'd0, cfg.gain_num});
        end
      end
      zrsm_pkg::ST_ABS: begin
        for (int i = 0; i < 2; i++) begin
          dvd[i] <= mag[i][DB-1:0];
          rem[i] <= '0;
          neg[i] <= prod[i][24];
        end
        div_cnt <= '0;
      end
      zrsm_pkg::ST_DIV: begin
        for (int i = 0; i < 2; i++) begin
          dvd[i] <= dvd_next[i];
          rem[i] <= rem_next[i];
        end
        div_cnt <= div_cnt + 1'b1;
      end
      zrsm_pkg::ST_SIGN: begin
        for (int i = 0; i < 2; i++) begin
          gain[i] <= neg[i] ? -$signed({1'b0, dvd[i]}) : $signed({1'b0, dvd[i]});
        end
      end
      zrsm_pkg::ST_SUM: begin
        pend.mixed <= 1'b1;
        if (cfg.stereo) begin
          pend.out_left <= sat_l;
          pend.out_right <= sat_r;
        end else begin
          pend.out_left <= sat_m;
        end
      end
      zrsm_pkg::ST_ADV: begin
        if (phase_ge && fifo_stat.empty) begin
          pend.underrun <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/zoh_resampler_saturating_mixer_unit.sv
// channel   | direction | handshake                  | payload
// item      | in        | item_valid / item_ready     | mode, frame_*, host_*
// result    | out       | result_valid / result_ready | out_*, mixed, underrun, dropped
// config    | in        | cfg_we                      | cfg_index, cfg_data
//
// a frame push writes the fifo in DECODE; a pass-through or drop goes on to OUT
// a mixed sample runs MUL, ABS, DIV, SIGN, SUM and ADV, which pops frames as the phase
// advances; the one-bit-per-cycle gain divider (23 steps) runs both channels together
// a two-entry command queue lets items arrive while the back end works; the result
// register holds one finished transfer so the back end moves on under output stalls
// synchronous reset clears control state; the frame store needs no clearing pass
`default_nettype none
`include "zoh_resampler_saturating_mixer_unit_macros.svh"
module zoh_resampler_saturating_mixer_unit #(
  parameter int unsigned FIFO_DEPTH = zrsm_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic                                mode,
  input  wire logic signed [15:0]                  frame_left,
  input  wire logic signed [15:0]                  frame_right,
  input  wire logic signed [15:0]                  host_left,
  input  wire logic signed [15:0]                  host_right,
  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic signed [15:0]                       out_left,
  output logic signed [15:0]                       out_right,
  output logic                                     mixed,
  output logic                                     underrun,
  output logic                                     dropped,
  input  wire logic                                cfg_we,
  input  wire logic [zrsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [zrsm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  zrsm_pkg::cfg_t       cfg;
  logic                 cmd_valid;
  zrsm_pkg::cmd_t       cmd;
  logic                 cmd_take;
  zrsm_pkg::fifo_ctl_t  fifo_ctl;
  zrsm_pkg::fifo_stat_t fifo_stat;
  logic [31:0]          fifo_wdata;
  logic [31:0]          fifo_rdata;
  logic [CW-1:0]        fifo_count;
  zrsm_pkg::res_t       res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enabled <= zrsm_pkg::RST_ENABLED;
      cfg.stereo <= zrsm_pkg::RST_STEREO;
      cfg.phase_step <= zrsm_pkg::RST_PHASE_STEP;
      cfg.phase_modulus <= zrsm_pkg::RST_PHASE_MODULUS;
      cfg.gain_num <= zrsm_pkg::RST_GAIN_NUM;
      cfg.gain_den <= zrsm_pkg::RST_GAIN_DEN;
    end else if (cfg_we) begin
      case (cfg_index)
        zrsm_pkg::CFG_ENABLED: cfg.enabled <= cfg_data[0];
        zrsm_pkg::CFG_STEREO: cfg.stereo <= cfg_data[0];
        zrsm_pkg::CFG_PHASE_STEP: cfg.phase_step <= cfg_data[25:0];
        zrsm_pkg::CFG_PHASE_MODULUS: cfg.phase_modulus <= cfg_data[31:0];
        zrsm_pkg::CFG_GAIN_NUM: cfg.gain_num <= cfg_data[7:0];
        zrsm_pkg::CFG_GAIN_DEN: cfg.gain_den <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  zrsm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .mode        (mode),
    .frame_left  (frame_left),
    .frame_right (frame_right),
    .host_left   (host_left),
    .host_right  (host_right),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  zrsm_frame_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_frame_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fifo_ctl),
    .wdata (fifo_wdata),
    .rdata (fifo_rdata),
    .stat  (fifo_stat),
    .count (fifo_count)
  );

  zrsm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .fifo_ctl     (fifo_ctl),
    .fifo_wdata   (fifo_wdata),
    .fifo_rdata   (fifo_rdata),
    .fifo_stat    (fifo_stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .res          (res)
  );

  assign out_left = res.out_left;
  assign out_right = res.out_right;
  assign mixed = res.mixed;
  assign underrun = res.underrun;
  assign dropped = res.dropped;

  `ZRSM_ASSERT_ALWAYS(a_count_bound, clk, rst, fifo_count <= CW'(FIFO_DEPTH), "frame count past depth")
  `ZRSM_ASSERT_ALWAYS(a_no_push_pop, clk, rst, !(fifo_ctl.push && fifo_ctl.pop), "push and pop together")
  `ZRSM_ASSERT_IMPL(a_pop_nonempty, clk, rst, fifo_ctl.pop, !fifo_stat.empty, "pop from empty store")
  `ZRSM_ASSERT_NEXT(a_push_count, clk, rst, fifo_ctl.push, fifo_count == $past(fifo_count) + 1'b1, "push lost")

endmodule
`default_nettype wire
